@@ rtl/core/pfma_pkg.sv @@
package pfma_pkg;

  localparam int unsigned ModBits  = 31;
  localparam int unsigned OpBits   = 3;
  localparam int unsigned WordBits = 32;
  localparam int unsigned CoefBits = 33;
  localparam int unsigned ProdBits = 64;

  localparam logic [OpBits-1:0] OP_ADD = 3'd0;
  localparam logic [OpBits-1:0] OP_SUB = 3'd1;
  localparam logic [OpBits-1:0] OP_MUL = 3'd2;
  localparam logic [OpBits-1:0] OP_DIV = 3'd3;
  localparam logic [OpBits-1:0] OP_POW = 3'd4;
  localparam logic [OpBits-1:0] OP_INV = 3'd5;

  typedef enum logic [2:0] {
    SRC_SA,
    SRC_SB,
    SRC_PROD,
    SRC_X,
    SRC_EUC
  } src_e;

  typedef enum logic [2:0] {
    DST_A,
    DST_B,
    DST_RES,
    DST_BASE,
    DST_INV
  } dst_e;

  typedef enum logic [2:0] {
    MUL_AB,
    MUL_A_INV,
    MUL_RES_BASE,
    MUL_BASE_BASE,
    MUL_Q_X1
  } mul_e;

  typedef struct packed {
    logic load;
    logic div_go;
    src_e div_src;
    logic red_wr;
    dst_e red_dst;
    logic mul_go;
    mul_e mul_sel;
    logic add_wr;
    logic sub_wr;
    logic set_err;
    logic inv_init;
    logic inv_src_b;
    logic euc_upd;
    logic pow_init;
    logic pow_shift;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic              div_done;
    logic [OpBits-1:0] op;
    logic              sb_neg;
    logic              a_zero;
    logic              b_zero;
    logic              p_zero;
    logic              e_lsb;
  } sts_t;

endpackage

@@ rtl/core/prime_field_modular_alu_core.sv @@
// Cost: inverse and div grow with the number of Euclid steps; pow takes at most two
// 64-step remainders per exponent bit, plus one inverse for a negative exponent.
// Throughput: one transfer at a time; the shared bit-serial remainder unit sets the rate.
// A new item is taken while the previous result waits in the output register.
// Reset: asynchronous, active low; modulus returns to 1000000007, no result pending.
module prime_field_modular_alu_core #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pfma_pkg::ModBits-1:0]          cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [pfma_pkg::OpBits-1:0]           req_type_i,
  input  logic signed [pfma_pkg::WordBits-1:0]  operand_a_i,
  input  logic signed [pfma_pkg::WordBits-1:0]  operand_b_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [pfma_pkg::ModBits-1:0]          result_o,
  output logic                                  no_inverse_o
);

  pfma_pkg::cmd_t cmd;
  pfma_pkg::sts_t sts;

  pfma_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pfma_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_type_i   (req_type_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .result_o     (result_o),
    .no_inverse_o (no_inverse_o)
  );

endmodule

@@ rtl/core/pfma_div.sv @@
module pfma_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                long_i,
  input  logic [pfma_pkg::ProdBits-1:0]       dividend_i,
  input  logic [pfma_pkg::ModBits-1:0]        divisor_i,
  output logic                                done_o,
  output logic [pfma_pkg::ModBits-1:0]        quot_o,
  output logic [pfma_pkg::ModBits-1:0]        rem_o
);

  logic [pfma_pkg::ProdBits-1:0] dvd_q, dvd_d;
  logic [pfma_pkg::ModBits:0]    rem_q, rem_d, sh;
  logic [pfma_pkg::ModBits-1:0]  dsr_q;
  logic [6:0]                    cnt_q;
  logic                          busy_q, done_q, ge;

  always_comb begin
    sh    = {rem_q[pfma_pkg::ModBits-1:0], dvd_q[pfma_pkg::ProdBits-1]};
    ge    = sh >= {1'b0, dsr_q};
    rem_d = ge ? sh - {1'b0, dsr_q} : sh;
    dvd_d = {dvd_q[pfma_pkg::ProdBits-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= long_i ? 7'd64 : 7'd34;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q[pfma_pkg::ModBits-1:0];
  assign rem_o  = rem_q[pfma_pkg::ModBits-1:0];

endmodule

@@ rtl/core/pfma_dp.sv @@
module pfma_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pfma_pkg::ModBits-1:0]      cfg_wdata_i,
  input  logic [pfma_pkg::OpBits-1:0]       req_type_i,
  input  logic signed [pfma_pkg::WordBits-1:0] operand_a_i,
  input  logic signed [pfma_pkg::WordBits-1:0] operand_b_i,
  input  pfma_pkg::cmd_t                    cmd_i,
  output pfma_pkg::sts_t                    sts_o,
  output logic [pfma_pkg::ModBits-1:0]      result_o,
  output logic                              no_inverse_o
);

  localparam int unsigned MB = pfma_pkg::ModBits;
  localparam int unsigned CB = pfma_pkg::CoefBits;

  logic [MB-1:0]                  mod_q, m_eff;
  logic [pfma_pkg::OpBits-1:0]    op_q;
  logic signed [pfma_pkg::WordBits-1:0] sa_q, sb_q;
  logic [MB-1:0]                  a_q, b_q, res_q, base_q, inv_q, n_q, p_q;
  logic [pfma_pkg::WordBits-1:0]  e_q;
  logic signed [CB-1:0]           x_q, x1_q;
  logic [pfma_pkg::ProdBits-1:0]  prod_q;
  logic                           err_q, neg_q;
  logic [MB-1:0]                  res_out_q;
  logic                           err_out_q;

  logic                           div_done, div_long;
  logic [MB-1:0]                  div_quot, div_rem, div_dsr, fixed;
  logic [pfma_pkg::ProdBits-1:0]  div_dvd;
  logic signed [33:0]             sval, smag;
  logic                           sneg;
  logic signed [CB-1:0]           mul_x;
  logic signed [pfma_pkg::WordBits-1:0] mul_y;
  logic signed [CB+pfma_pkg::WordBits-1:0] mul_p;
  logic [MB:0]                    sum, dif;

  assign m_eff = (mod_q == '0) ? MB'(1) : mod_q;

  always_comb begin
    sval = '0;
    case (cmd_i.div_src)
      pfma_pkg::SRC_SA: sval = 34'(sa_q);
      pfma_pkg::SRC_SB: sval = 34'(sb_q);
      pfma_pkg::SRC_X:  sval = 34'(x_q);
      default:          sval = $signed({3'b000, n_q});
    endcase
    sneg = sval[33];
    smag = sneg ? -sval : sval;
    div_long = cmd_i.div_src == pfma_pkg::SRC_PROD;
    div_dvd  = div_long ? prod_q : {smag, 30'b0};
    div_dsr  = (cmd_i.div_src == pfma_pkg::SRC_EUC) ? p_q : m_eff;
  end

  pfma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .long_i     (div_long),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign fixed = (neg_q && div_rem != '0) ? m_eff - div_rem : div_rem;

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (cmd_i.mul_sel)
      pfma_pkg::MUL_AB:        begin mul_x = CB'(a_q);    mul_y = 32'(b_q);    end
      pfma_pkg::MUL_A_INV:     begin mul_x = CB'(a_q);    mul_y = 32'(inv_q);  end
      pfma_pkg::MUL_RES_BASE:  begin mul_x = CB'(res_q);  mul_y = 32'(base_q); end
      pfma_pkg::MUL_BASE_BASE: begin mul_x = CB'(base_q); mul_y = 32'(base_q); end
      default:                 begin mul_x = x1_q;        mul_y = 32'(div_quot); end
    endcase
    mul_p = mul_x * mul_y;
    sum   = {1'b0, a_q} + {1'b0, b_q};
    dif   = (a_q >= b_q) ? {1'b0, a_q} - {1'b0, b_q}
                         : {1'b0, a_q} + {1'b0, m_eff} - {1'b0, b_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MB'(1000000007);
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= req_type_i;
      sa_q  <= operand_a_i;
      sb_q  <= operand_b_i;
      res_q <= '0;
      err_q <= 1'b0;
    end
    if (cmd_i.div_go) begin
      neg_q <= sneg && !div_long;
    end
    if (cmd_i.red_wr && div_done) begin
      case (cmd_i.red_dst)
        pfma_pkg::DST_A:    a_q    <= fixed;
        pfma_pkg::DST_B:    b_q    <= fixed;
        pfma_pkg::DST_RES:  res_q  <= fixed;
        pfma_pkg::DST_BASE: base_q <= fixed;
        default:            inv_q  <= fixed;
      endcase
    end
    if (cmd_i.mul_go) begin
      prod_q <= mul_p[pfma_pkg::ProdBits-1:0];
    end
    if (cmd_i.add_wr) begin
      res_q <= (sum >= {1'b0, m_eff}) ? MB'(sum - {1'b0, m_eff}) : sum[MB-1:0];
    end
    if (cmd_i.sub_wr) begin
      res_q <= dif[MB-1:0];
    end
    if (cmd_i.set_err) begin
      err_q <= 1'b1;
      res_q <= '0;
    end
    if (cmd_i.inv_init) begin
      n_q  <= cmd_i.inv_src_b ? b_q : a_q;
      p_q  <= m_eff;
      x_q  <= CB'(1);
      x1_q <= '0;
    end
    if (cmd_i.euc_upd) begin
      x_q  <= x1_q;
      x1_q <= x_q - $signed(prod_q[CB-1:0]);
      n_q  <= p_q;
      p_q  <= div_rem;
    end
    if (cmd_i.pow_init) begin
      base_q <= sb_q[pfma_pkg::WordBits-1] ? inv_q : a_q;
      e_q    <= sb_q[pfma_pkg::WordBits-1] ? 32'(-sb_q) : 32'(sb_q);
      res_q  <= (m_eff == MB'(1)) ? '0 : MB'(1);
    end
    if (cmd_i.pow_shift) begin
      e_q <= e_q >> 1;
    end
    if (cmd_i.out_load) begin
      res_out_q <= err_q ? '0 : res_q;
      err_out_q <= err_q;
    end
  end

  always_comb begin
    sts_o.div_done = div_done;
    sts_o.op       = op_q;
    sts_o.sb_neg   = sb_q[pfma_pkg::WordBits-1];
    sts_o.a_zero   = a_q == '0;
    sts_o.b_zero   = b_q == '0;
    sts_o.p_zero   = p_q == '0;
    sts_o.e_lsb    = e_q[0];
  end

  assign result_o     = res_out_q;
  assign no_inverse_o = err_out_q;

endmodule

@@ rtl/core/pfma_ctrl.sv @@
module pfma_ctrl #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  pfma_pkg::sts_t sts_i,
  output pfma_pkg::cmd_t cmd_o
);

  localparam int unsigned CW = $clog2(WORD_BITS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_RA_GO, S_RA_WAIT, S_RB_GO, S_RB_WAIT, S_DISP, S_ADD, S_SUB, S_ERR,
    S_DIV_MUL, S_POW_INIT, S_POW_CHK, S_POW_SQ, S_POW_NEXT, S_MM_MUL, S_MM_GO,
    S_MM_WAIT, S_INV_INIT, S_INV_CHK, S_INV_DGO, S_INV_DWAIT, S_INV_MUL, S_INV_UPD,
    S_INV_RGO, S_INV_RWAIT, S_FIN
  } state_e;

  state_e         state_q, mm_ret_q, inv_ret_q;
  pfma_pkg::mul_e mm_sel_q;
  pfma_pkg::dst_e mm_dst_q, inv_dst_q;
  logic           inv_src_q, out_valid_q;
  logic [CW-1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mm_ret_q    <= S_IDLE;
      inv_ret_q   <= S_IDLE;
      mm_sel_q    <= pfma_pkg::MUL_AB;
      mm_dst_q    <= pfma_pkg::DST_RES;
      inv_dst_q   <= pfma_pkg::DST_INV;
      inv_src_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (state_q == S_FIN && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:    if (in_valid_i) state_q <= S_RA_GO;
        S_RA_GO:   state_q <= S_RA_WAIT;
        S_RA_WAIT: if (sts_i.div_done) state_q <= S_RB_GO;
        S_RB_GO:   state_q <= S_RB_WAIT;
        S_RB_WAIT: if (sts_i.div_done) state_q <= S_DISP;
        S_DISP: begin
          unique case (sts_i.op)
            pfma_pkg::OP_ADD: state_q <= S_ADD;
            pfma_pkg::OP_SUB: state_q <= S_SUB;
            pfma_pkg::OP_MUL: begin
              mm_sel_q <= pfma_pkg::MUL_AB;
              mm_dst_q <= pfma_pkg::DST_RES;
              mm_ret_q <= S_FIN;
              state_q  <= S_MM_MUL;
            end
            pfma_pkg::OP_DIV: begin
              if (sts_i.b_zero) begin
                state_q <= S_ERR;
              end else begin
                inv_src_q <= 1'b1;
                inv_dst_q <= pfma_pkg::DST_INV;
                inv_ret_q <= S_DIV_MUL;
                state_q   <= S_INV_INIT;
              end
            end
            pfma_pkg::OP_POW: begin
              if (!sts_i.sb_neg) begin
                state_q <= S_POW_INIT;
              end else if (sts_i.a_zero) begin
                state_q <= S_ERR;
              end else begin
                inv_src_q <= 1'b0;
                inv_dst_q <= pfma_pkg::DST_INV;
                inv_ret_q <= S_POW_INIT;
                state_q   <= S_INV_INIT;
              end
            end
            pfma_pkg::OP_INV: begin
              if (sts_i.a_zero) begin
                state_q <= S_ERR;
              end else begin
                inv_src_q <= 1'b0;
                inv_dst_q <= pfma_pkg::DST_RES;
                inv_ret_q <= S_FIN;
                state_q   <= S_INV_INIT;
              end
            end
            default: state_q <= S_FIN;
          endcase
        end
        S_ADD, S_SUB, S_ERR: state_q <= S_FIN;
        S_DIV_MUL: begin
          mm_sel_q <= pfma_pkg::MUL_A_INV;
          mm_dst_q <= pfma_pkg::DST_RES;
          mm_ret_q <= S_FIN;
          state_q  <= S_MM_MUL;
        end
        S_POW_INIT: begin
          cnt_q   <= '0;
          state_q <= S_POW_CHK;
        end
        S_POW_CHK: begin
          if (cnt_q == CW'(WORD_BITS)) begin
            state_q <= S_FIN;
          end else if (sts_i.e_lsb) begin
            mm_sel_q <= pfma_pkg::MUL_RES_BASE;
            mm_dst_q <= pfma_pkg::DST_RES;
            mm_ret_q <= S_POW_SQ;
            state_q  <= S_MM_MUL;
          end else begin
            state_q <= S_POW_SQ;
          end
        end
        S_POW_SQ: begin
          mm_sel_q <= pfma_pkg::MUL_BASE_BASE;
          mm_dst_q <= pfma_pkg::DST_BASE;
          mm_ret_q <= S_POW_NEXT;
          state_q  <= S_MM_MUL;
        end
        S_POW_NEXT: begin
          cnt_q   <= cnt_q + CW'(1);
          state_q <= S_POW_CHK;
        end
        S_MM_MUL:    state_q <= S_MM_GO;
        S_MM_GO:     state_q <= S_MM_WAIT;
        S_MM_WAIT:   if (sts_i.div_done) state_q <= mm_ret_q;
        S_INV_INIT:  state_q <= S_INV_CHK;
        S_INV_CHK:   state_q <= sts_i.p_zero ? S_INV_RGO : S_INV_DGO;
        S_INV_DGO:   state_q <= S_INV_DWAIT;
        S_INV_DWAIT: if (sts_i.div_done) state_q <= S_INV_MUL;
        S_INV_MUL:   state_q <= S_INV_UPD;
        S_INV_UPD:   state_q <= S_INV_CHK;
        S_INV_RGO:   state_q <= S_INV_RWAIT;
        S_INV_RWAIT: if (sts_i.div_done) state_q <= inv_ret_q;
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.div_src   = pfma_pkg::SRC_SA;
    cmd_o.red_dst   = pfma_pkg::DST_A;
    cmd_o.mul_sel   = mm_sel_q;
    cmd_o.inv_src_b = inv_src_q;
    unique case (state_q)
      S_IDLE:    cmd_o.load = in_valid_i;
      S_RA_GO:   cmd_o.div_go = 1'b1;
      S_RA_WAIT: cmd_o.red_wr = 1'b1;
      S_RB_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_src = pfma_pkg::SRC_SB;
      end
      S_RB_WAIT: begin
        cmd_o.red_wr  = 1'b1;
        cmd_o.red_dst = pfma_pkg::DST_B;
      end
      S_ADD:      cmd_o.add_wr    = 1'b1;
      S_SUB:      cmd_o.sub_wr    = 1'b1;
      S_ERR:      cmd_o.set_err   = 1'b1;
      S_POW_INIT: cmd_o.pow_init  = 1'b1;
      S_POW_NEXT: cmd_o.pow_shift = 1'b1;
      S_MM_MUL:   cmd_o.mul_go    = 1'b1;
      S_MM_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_src = pfma_pkg::SRC_PROD;
      end
      S_MM_WAIT: begin
        cmd_o.red_wr  = 1'b1;
        cmd_o.red_dst = mm_dst_q;
      end
      S_INV_INIT: cmd_o.inv_init = 1'b1;
      S_INV_DGO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_src = pfma_pkg::SRC_EUC;
      end
      S_INV_MUL: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = pfma_pkg::MUL_Q_X1;
      end
      S_INV_UPD: cmd_o.euc_upd = 1'b1;
      S_INV_RGO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_src = pfma_pkg::SRC_X;
      end
      S_INV_RWAIT: begin
        cmd_o.red_wr  = 1'b1;
        cmd_o.red_dst = inv_dst_q;
      end
      S_FIN:   cmd_o.out_load = !out_valid_q || !out_stall_i;
      default: cmd_o.load = 1'b0;
    endcase
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule
